/* sv/bfst_pkg.sv */
// Shared types and constants for the byte frequency first-seen table.
// Used by bfst_table and byte_frequency_first_seen_table_top.
package bfst_pkg;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int CNT_W             = 7;   // entry counter / distinct count width
	localparam int OCC_W             = 16;
	localparam logic [OCC_W-1:0] SAT16 = 16'hFFFF;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_value;
	} item_t;

	typedef struct packed {
		logic [7:0]       symbol;
		logic [OCC_W-1:0] occurrences;
		logic             entry_valid;
		logic [CNT_W-1:0] distinct_count;
		logic [OCC_W-1:0] total_length;
		logic             overflowed;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [7:0]       symbol;
		logic [OCC_W-1:0] count;
	} entry_t;

endpackage

/* sv/byte_frequency_first_seen_table_top.sv */
// Byte histogram in first-seen order, one sequential compare unit over the table.
// A byte word is compared with the table entries one by one (one read/compare per
// entry, one table read port); once the table overflowed it only counts the length. An end word
// reads each entry out in turn through the single read port, and output stalls can hold it.
// One word is worked on at a time. arst_n clears control state and counters;
// the entry store is not cleared. Depends on bfst_pkg and bfst_table.
module byte_frequency_first_seen_table_top #(
	parameter int TABLE_ENTRIES = bfst_pkg::DEF_TABLE_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  bfst_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output bfst_pkg::result_t result
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [bfst_pkg::CNT_W-1:0] NUM_ENTRIES = bfst_pkg::CNT_W'(TABLE_ENTRIES);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_RPT    = 4'b0100,
		ST_RPT_LD = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [bfst_pkg::CNT_W-1:0]     idx_q;
	logic [bfst_pkg::CNT_W-1:0]     cmp_idx_q;
	logic                           rd_pend_q;
	logic [7:0]                     char_q;
	logic [bfst_pkg::CNT_W-1:0]     used_q;
	logic [bfst_pkg::OCC_W-1:0]     len_q;
	logic                           full_q;
	logic                           out_valid_q;
	bfst_pkg::result_t              out_q;

	logic                           in_acc;
	logic                           out_acc;
	logic                           out_free;
	logic                           hit;
	logic                           wr_en;
	logic [IDX_W-1:0]               wr_addr;
	bfst_pkg::entry_t               wr_data;
	bfst_pkg::entry_t               rd_data;
	logic [bfst_pkg::OCC_W-1:0]     cnt_inc;

	assign item_ready   = (state_q == ST_IDLE);
	assign in_acc       = item_valid && item_ready;
	assign out_acc      = out_valid_q && result_ready;
	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign hit     = rd_pend_q && (rd_data.symbol == char_q);
	assign cnt_inc = (rd_data.count == bfst_pkg::SAT16) ? bfst_pkg::SAT16
	                                                     : rd_data.count + 16'd1;

	// table write: count bump on a hit, new entry on a miss with room left
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmp_idx_q[IDX_W-1:0];
		wr_data = '{symbol: char_q, count: cnt_inc};
		if (state_q == ST_SCAN) begin
			if (hit) begin
				wr_en = 1'b1;
			end else if (idx_q == used_q && used_q < NUM_ENTRIES) begin
				wr_en   = 1'b1;
				wr_addr = used_q[IDX_W-1:0];
				wr_data = '{symbol: char_q, count: 16'd1};
			end
		end
	end

	bfst_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W        (IDX_W)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(idx_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cmp_idx_q   <= '0;
			rd_pend_q   <= 1'b0;
			char_q      <= '0;
			used_q      <= '0;
			len_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q     <= '0;
						rd_pend_q <= 1'b0;
						char_q    <= item.char_value;
						if (item.kind == bfst_pkg::KIND_END) begin
							state_q <= ST_RPT;
						end else begin
							if (len_q != bfst_pkg::SAT16) begin
								len_q <= len_q + 16'd1;
							end
							if (!full_q) begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						state_q <= ST_IDLE;
					end else if (idx_q == used_q) begin
						// every entry compared, byte is new
						if (used_q < NUM_ENTRIES) begin
							used_q <= used_q + 7'd1;
						end else begin
							full_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						cmp_idx_q <= idx_q;
						rd_pend_q <= 1'b1;
						idx_q     <= idx_q + 7'd1;
					end
				end
				ST_RPT: begin
					if (out_free) begin
						if (used_q == '0) begin
							out_valid_q <= 1'b1;
							used_q      <= '0;
							len_q       <= '0;
							full_q      <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							// read issued at idx_q this cycle
							state_q <= ST_RPT_LD;
						end
					end
				end
				ST_RPT_LD: begin
					out_valid_q <= 1'b1;
					idx_q       <= idx_q + 7'd1;
					if (idx_q + 7'd1 == used_q) begin
						used_q  <= '0;
						len_q   <= '0;
						full_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RPT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, loaded only while the output slot is free
	always_ff @(posedge clk) begin
		if (state_q == ST_RPT && out_free && used_q == '0) begin
			out_q <= '{symbol: 8'd0, occurrences: 16'd0, entry_valid: 1'b0,
			           distinct_count: 7'd0, total_length: len_q,
			           overflowed: full_q, last: 1'b1};
		end else if (state_q == ST_RPT_LD) begin
			out_q <= '{symbol: rd_data.symbol, occurrences: rd_data.count,
			           entry_valid: 1'b1, distinct_count: used_q,
			           total_length: len_q, overflowed: full_q,
			           last: (idx_q + 7'd1 == used_q)};
		end
	end

endmodule

/* sv/bfst_table.sv */
// Entry store: symbol and count per table entry, one write and one read port.
// Read data registered. Depends on bfst_pkg.
module bfst_table #(
	parameter int TABLE_ENTRIES = bfst_pkg::DEF_TABLE_ENTRIES,
	parameter int IDX_W         = 6
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  bfst_pkg::entry_t      wr_data,
	input  logic [IDX_W-1:0]      rd_addr,
	output bfst_pkg::entry_t      rd_data
);

	bfst_pkg::entry_t mem_q [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* tb/tb.sv */
// Self-checking bench for byte_frequency_first_seen_table_top: directed and random strings
// and reports with valid/ready pacing on both sides, checked against an in-bench histogram
// predictor. Depends on bfst_pkg and the block's RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES       = bfst_pkg::DEF_TABLE_ENTRIES;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int RANDOM_WORDS  = 180;
	localparam int QUIET_WORDS   = 40;  // tail of the random part runs without idling
	localparam int SETTLE_CYCLES = 300;

	// Tracks the first-seen table of the current string and queues the report words
	// that each end-of-string word must produce.
	class hist_scoreboard;
		logic [7:0]                 seen_symbols [ENTRIES];
		logic [bfst_pkg::OCC_W-1:0] seen_counts  [ENTRIES];
		int                         n_distinct = 0;
		logic [bfst_pkg::OCC_W-1:0] string_len = '0;
		bit                         table_overflow = 1'b0;
		bfst_pkg::result_t          pending_results [$];
		int errors = 0, checked = 0, words = 0, reports = 0;
		int overflow_reports = 0, saturated_reports = 0;

		function int pending();
			return pending_results.size();
		endfunction

		function void note_word(bfst_pkg::item_t w);
			bfst_pkg::result_t r;
			int                hit;
			words++;
			if (w.kind == bfst_pkg::KIND_BYTE) begin
				if (string_len != bfst_pkg::SAT16)
					string_len++;
				if (!table_overflow) begin
					hit = -1;
					for (int k = 0; k < n_distinct; k++)
						if (seen_symbols[k] == w.char_value)
							hit = k;
					if (hit >= 0) begin
						if (seen_counts[hit] != bfst_pkg::SAT16)
							seen_counts[hit]++;
					end else if (n_distinct == ENTRIES) begin
						table_overflow = 1'b1;  // frozen until the end word
					end else begin
						seen_symbols[n_distinct] = w.char_value;
						seen_counts[n_distinct]  = 16'd1;
						n_distinct++;
					end
				end
				return;
			end
			reports++;
			overflow_reports  += table_overflow;
			saturated_reports += (string_len == bfst_pkg::SAT16);
			r.distinct_count = bfst_pkg::CNT_W'(n_distinct);
			r.total_length   = string_len;
			r.overflowed     = table_overflow;
			if (n_distinct == 0) begin
				r.symbol      = '0;
				r.occurrences = '0;
				r.entry_valid = 1'b0;
				r.last        = 1'b1;
				pending_results.push_back(r);
			end else begin
				for (int k = 0; k < n_distinct; k++) begin
					r.symbol      = seen_symbols[k];
					r.occurrences = seen_counts[k];
					r.entry_valid = 1'b1;
					r.last        = (k == n_distinct - 1);
					pending_results.push_back(r);
				end
			end
			n_distinct     = 0;
			string_len     = '0;
			table_overflow = 1'b0;
		endfunction

		task report(string msg);
			$display("[%0t] ERROR: %s", $time, msg);
			errors++;
		endtask

		task check_result(bfst_pkg::result_t got);
			bfst_pkg::result_t want;
			checked++;
			if (pending_results.size() == 0) begin
				report($sformatf("result word %h with nothing expected", got));
				return;
			end
			want = pending_results.pop_front();
			if (got.symbol !== want.symbol)
				report($sformatf("symbol %h, expected %h", got.symbol, want.symbol));
			if (got.occurrences !== want.occurrences)
				report($sformatf("occurrences %0d, expected %0d (symbol %h)",
					got.occurrences, want.occurrences, want.symbol));
			if (got.entry_valid !== want.entry_valid)
				report($sformatf("entry_valid %b, expected %b", got.entry_valid,
					want.entry_valid));
			if (got.distinct_count !== want.distinct_count)
				report($sformatf("distinct_count %0d, expected %0d", got.distinct_count,
					want.distinct_count));
			if (got.total_length !== want.total_length)
				report($sformatf("total_length %0d, expected %0d", got.total_length,
					want.total_length));
			if (got.overflowed !== want.overflowed)
				report($sformatf("overflowed %b, expected %b", got.overflowed,
					want.overflowed));
			if (got.last !== want.last)
				report($sformatf("last %b, expected %b (symbol %h)", got.last, want.last,
					want.symbol));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	bfst_pkg::item_t   item;
	logic              result_valid;
	logic              result_ready;
	bfst_pkg::result_t result;

	hist_scoreboard sb = new();
	bit send_idle = 1'b0;
	bit sink_stall = 1'b0;
	int cycles = 0;

	byte_frequency_first_seen_table_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_ready = 1'b0;
	end

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: check accepted words, stall in bursts when enabled.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				sb.check_result(result);
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (arst_n && sink_stall && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 11);
				result_ready <= 1'b0;
			end else begin
				result_ready <= arst_n;
			end
		end
	end

	// Offers one word and returns on the edge that accepts it; valid stays up.
	task push_word(bfst_pkg::item_t w);
		if (send_idle && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_word(w);
	endtask

	task push_byte(logic [7:0] b);
		bfst_pkg::item_t w;
		w.kind       = bfst_pkg::KIND_BYTE;
		w.char_value = b;
		push_word(w);
	endtask

	task push_end();
		bfst_pkg::item_t w;
		w.kind       = bfst_pkg::KIND_END;
		w.char_value = 8'($urandom);  // ignored on an end word
		push_word(w);
	endtask

	// base, base+step, ... are distinct for n <= 256 since step is odd
	task push_distinct(int n, logic [7:0] base, logic [7:0] step);
		for (int k = 0; k < n; k++)
			push_byte(base + 8'(k) * step);
	endtask

	// Holds the sender off until every report word has come back.
	task drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin
		logic [7:0] alpha [16];
		logic [7:0] base, step;
		int         start_words, len, span, pick;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty report, byte extremes with repeats, clear between strings
		send_idle  = 1'b1;
		sink_stall = 1'b1;
		push_end();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_end();
		push_byte(8'h55);
		push_byte(8'hAA);
		push_end();
		push_end();

		// exactly full table, then one new byte past full
		base = 8'($urandom);
		step = 8'($urandom_range(0, 127) * 2 + 1);
		push_distinct(ENTRIES, base, step);
		push_end();
		base = 8'($urandom);
		step = 8'($urandom_range(0, 127) * 2 + 1);
		push_distinct(ENTRIES, base, step);
		push_byte(base);
		push_byte(base + 8'(ENTRIES) * step);
		push_byte(base);              // table frozen, must not count
		push_byte(base + step);
		push_end();
		drain();

		// random strings, mostly well formed with small alphabets
		start_words = sb.words;
		while (sb.words - start_words < RANDOM_WORDS) begin
			if (sb.words - start_words > RANDOM_WORDS - QUIET_WORDS) begin
				send_idle  = 1'b0;
				sink_stall = 1'b0;
			end else begin
				send_idle  = ($urandom_range(0, 3) != 0);
				sink_stall = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				span = $urandom_range(1, 16);
				foreach (alpha[i])
					alpha[i] = 8'($urandom);
				len = $urandom_range(1, 24);
				repeat (len) push_byte(alpha[$urandom_range(0, span - 1)]);
			end else if (pick == 7) begin
				// wide alphabet around the table size, often overflows
				base = 8'($urandom);
				step = 8'($urandom_range(0, 127) * 2 + 1);
				span = $urandom_range(60, 80);
				len  = $urandom_range(40, 120);
				repeat (len) push_byte(base + 8'($urandom_range(0, span - 1)) * step);
			end else if (pick == 8) begin
				len = $urandom_range(1, 70);
				repeat (len) push_byte(8'($urandom));
			end else if ($urandom_range(0, 1) == 0) begin
				push_end();  // extra empty report
			end
			push_end();
			if ($urandom_range(0, 9) == 0)
				drain();
		end

		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d words in %0d string reports (%0d overflowed, %0d saturated).",
			sb.words, sb.reports, sb.overflow_reports, sb.saturated_reports);
		$display("Checked %0d result words, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
